### hdl/dense_matrix_multiply_macros.svh
// assertion macros for the matrix multiply checker
// used by dmm_checker.sv only
`ifndef DENSE_MATRIX_MULTIPLY_MACROS_SVH
`define DENSE_MATRIX_MULTIPLY_MACROS_SVH

// antecedent implies consequent in the next cycle
`define DMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmm checker: next-cycle property failed");

// antecedent implies consequent in the same cycle
`define DMM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmm checker: same-cycle property failed");

`endif

### hdl/dmm_pkg.sv
// shared types and constants for the dense matrix multiply block
// no dependencies
package dmm_pkg;

  localparam int DEF_ROWS_LEFT  = 4;
  localparam int DEF_INNER_DIM  = 4;
  localparam int DEF_COLS_RIGHT = 4;
  localparam int DEF_ELEM_WIDTH = 16;

  localparam int STORE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int VAL_W       = 16;
  localparam int POS_W       = 9;
  localparam int ACC_W       = 34;
  localparam int MAX_OUT     = 16;
  localparam int CNT_W       = 4;
  localparam int CMD_W       = 2;
  localparam int COORD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_WR_LEFT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_RIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PRODUCT  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } dmm_state_t;

  typedef struct packed {
    logic wr_left;
    logic wr_right;
    logic start;
    logic mac;
    logic emit;
  } dmm_ctl_t;

  typedef struct packed {
    logic k_last;
    logic run_last;
    logic out_free;
  } dmm_status_t;

endpackage

### hdl/dmm_if.sv
// request and result channel interfaces
// depends on dmm_pkg
interface dmm_req_if import dmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_W-1:0]         element_index;
  logic signed [VAL_W-1:0]  element_value;

  modport source (output valid, cmd, element_index, element_value, input ready);
  modport sink (input valid, cmd, element_index, element_value, output ready);
endinterface

interface dmm_res_if import dmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [COORD_W-1:0]       out_row;
  logic [COORD_W-1:0]       out_col;
  logic signed [ACC_W-1:0]  product_value;
  logic                     last;

  modport source (output valid, out_row, out_col, product_value, last, input ready);
  modport sink (input valid, out_row, out_col, product_value, last, output ready);
endinterface

### hdl/dmm_ctrl.sv
// controller state machine: sequences writes, multiply-accumulate and emit
// depends on dmm_pkg
module dmm_ctrl import dmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [CMD_W-1:0] req_cmd,
  output logic             req_ready,
  input  dmm_status_t      status,
  output dmm_ctl_t         ctl
);

  dmm_state_t state;
  dmm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (req_cmd)
            CMD_WR_LEFT: ctl.wr_left = 1'b1;
            CMD_WR_RIGHT: ctl.wr_right = 1'b1;
            CMD_PRODUCT: begin
              ctl.start  = 1'b1;
              state_next = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        ctl.mac = 1'b1;
        if (status.k_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          ctl.emit   = 1'b1;
          state_next = status.run_last ? ST_IDLE : ST_MAC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hdl/dmm_datapath.sv
// datapath: operand stores, index counters, multiply-accumulate, output register
// depends on dmm_pkg
module dmm_datapath import dmm_pkg::*; #(
  parameter int ROWS_LEFT  = DEF_ROWS_LEFT,
  parameter int INNER_DIM  = DEF_INNER_DIM,
  parameter int COLS_RIGHT = DEF_COLS_RIGHT,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dmm_ctl_t                 ctl,
  input  logic [IDX_W-1:0]         wr_index,
  input  logic signed [VAL_W-1:0]  wr_value,
  output dmm_status_t              status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COORD_W-1:0]       out_row,
  output logic [COORD_W-1:0]       out_col,
  output logic signed [ACC_W-1:0]  product_value,
  output logic                     last
);

  localparam int RW    = (ROWS_LEFT > 1) ? $clog2(ROWS_LEFT) : 1;
  localparam int CW    = (COLS_RIGHT > 1) ? $clog2(COLS_RIGHT) : 1;
  localparam int KW    = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;
  localparam int SW    = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;
  localparam int TOTAL = (ROWS_LEFT * COLS_RIGHT > MAX_OUT) ? MAX_OUT
                                                            : ROWS_LEFT * COLS_RIGHT;

  logic signed [VAL_W-1:0] left_store  [STORE_DEPTH];
  logic signed [VAL_W-1:0] right_store [STORE_DEPTH];

  logic [RW-1:0]           row;
  logic [CW-1:0]           col;
  logic [KW-1:0]           kk;
  logic [CNT_W-1:0]        count;
  logic signed [ACC_W-1:0] acc;

  logic [POS_W-1:0]        left_pos;
  logic [POS_W-1:0]        right_pos;
  logic signed [VAL_W-1:0] op_a;
  logic signed [VAL_W-1:0] op_b;
  logic signed [2*VAL_W-1:0] prod;
  logic [VAL_W-1:0]        wr_elem;

  function automatic logic [VAL_W-1:0] to_elem(input logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] v;
    for (int b = 0; b < VAL_W; b++) begin
      v[b] = (b < SW) ? x[b] : x[SW-1];
    end
    return v;
  endfunction

  assign wr_elem   = to_elem(wr_value);
  assign left_pos  = POS_W'(row) * POS_W'(INNER_DIM) + POS_W'(kk);
  assign right_pos = POS_W'(kk) * POS_W'(COLS_RIGHT) + POS_W'(col);
  assign op_a      = (left_pos < POS_W'(STORE_DEPTH)) ? left_store[left_pos[IDX_W-1:0]] : '0;
  assign op_b      = (right_pos < POS_W'(STORE_DEPTH)) ? right_store[right_pos[IDX_W-1:0]]
                                                       : '0;
  assign prod      = op_a * op_b;

  assign status.k_last   = (kk == KW'(INNER_DIM - 1));
  assign status.run_last = (count == CNT_W'(TOTAL - 1));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < STORE_DEPTH; e++) begin
        left_store[e]  <= '0;
        right_store[e] <= '0;
      end
    end else begin
      if (ctl.wr_left) begin
        left_store[wr_index] <= signed'(wr_elem);
      end
      if (ctl.wr_right) begin
        right_store[wr_index] <= signed'(wr_elem);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row   <= '0;
      col   <= '0;
      kk    <= '0;
      count <= '0;
      acc   <= '0;
    end else if (ctl.start) begin
      row   <= '0;
      col   <= '0;
      kk    <= '0;
      count <= '0;
      acc   <= '0;
    end else if (ctl.mac) begin
      acc <= acc + ACC_W'(prod);
      kk  <= status.k_last ? '0 : kk + 1'b1;
    end else if (ctl.emit) begin
      acc   <= '0;
      count <= count + 1'b1;
      if (col == CW'(COLS_RIGHT - 1)) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_row       <= COORD_W'(row);
      out_col       <= COORD_W'(col);
      product_value <= acc;
      last          <= status.run_last;
    end
  end

endmodule

### hdl/dense_matrix_multiply.sv
// top level of the dense matrix multiply block
// depends on dmm_pkg, dmm_if, dmm_ctrl, dmm_datapath
//
// request channel: one word per command. cmd 0 writes element_value into the
// left store at element_index, cmd 1 into the right store, cmd 2 asks for the
// product, cmd 3 does nothing. a write or a no-op leaves the controller idle, so the
// next word can follow in the next cycle.
// result channel: a product request returns min(ROWS_LEFT*COLS_RIGHT, 16)
// words in row-major order, last set on the final one.
// each product word is summed by the single multiply-accumulate unit, which
// steps one inner index per cycle, and is then loaded into the output register.
// request ready stays low from the product request until the final word is
// loaded into the output register.
// when the receiver stalls, the word is held in the output register and the
// accumulator holds the next finished sum until the register is free.
// reset clears both stores to zero, empties the output register and returns
// the controller to idle; no clearing pass is needed.
module dense_matrix_multiply import dmm_pkg::*; #(
  parameter int ROWS_LEFT  = DEF_ROWS_LEFT,
  parameter int INNER_DIM  = DEF_INNER_DIM,
  parameter int COLS_RIGHT = DEF_COLS_RIGHT,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input logic        clk,
  input logic        rst,
  dmm_req_if.sink    request,
  dmm_res_if.source  result
);

  dmm_ctl_t    ctl;
  dmm_status_t status;

  dmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_cmd   (request.cmd),
    .req_ready (request.ready),
    .status    (status),
    .ctl       (ctl)
  );

  dmm_datapath #(
    .ROWS_LEFT  (ROWS_LEFT),
    .INNER_DIM  (INNER_DIM),
    .COLS_RIGHT (COLS_RIGHT),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .wr_index      (request.element_index),
    .wr_value      (request.element_value),
    .status        (status),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_row       (result.out_row),
    .out_col       (result.out_col),
    .product_value (result.product_value),
    .last          (result.last)
  );

endmodule

### hdl/dmm_checker.sv
// port-level checker for the dense matrix multiply block, with its bind
// depends on dmm_pkg and dense_matrix_multiply_macros.svh
`include "dense_matrix_multiply_macros.svh"

module dmm_checker import dmm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic [CMD_W-1:0] req_cmd,
  input logic             res_valid,
  input logic             res_ready,
  input logic             res_last
);

  `DMM_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `DMM_ASSERT_NEXT(a_busy_after_product, clk, rst, req_valid && req_ready && req_cmd == CMD_PRODUCT, !req_ready)
  `DMM_ASSERT_NEXT(a_ready_after_write, clk, rst, req_valid && req_ready && req_cmd != CMD_PRODUCT, req_ready)
  `DMM_ASSERT_NEXT(a_quiet_after_last, clk, rst, res_valid && res_ready && res_last && req_ready, !res_valid)
  `DMM_ASSERT_NOW(a_idle_on_last, clk, rst, $rose(req_ready), res_valid && res_last)

endmodule

bind dense_matrix_multiply dmm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .req_cmd   (request.cmd),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_last  (result.last)
);

### test/tb_top.sv
// testbench for dense_matrix_multiply: drives element writes and product requests,
// predicts every product word and checks it in order through a small scoreboard class
// depends on dmm_pkg, dmm_req_if, dmm_res_if and dense_matrix_multiply
`timescale 1ns / 1ps

module tb_top;
  import dmm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 200;
  localparam int DRAIN_CYCLES = 4 * (DEF_INNER_DIM + 2);
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 22;

  typedef struct {
    logic [COORD_W-1:0]      row;
    logic [COORD_W-1:0]      col;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } product_word_t;

  class product_tracker;
    logic signed [VAL_W-1:0] left_m[STORE_DEPTH];
    logic signed [VAL_W-1:0] right_m[STORE_DEPTH];
    product_word_t pending_products[$];
    int unsigned errors;

    function new();
      foreach (left_m[i]) begin
        left_m[i] = '0;
        right_m[i] = '0;
      end
      errors = 0;
    endfunction

    function void apply_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                logic signed [VAL_W-1:0] val);
      longint acc;
      longint a;
      longint b;
      int total;
      int count;
      int pl;
      int pr;
      product_word_t w;
      case (cmd)
        CMD_WR_LEFT: begin
          left_m[idx] = val;
        end
        CMD_WR_RIGHT: begin
          right_m[idx] = val;
        end
        CMD_PRODUCT: begin
          total = DEF_ROWS_LEFT * DEF_COLS_RIGHT;
          if (total > MAX_OUT) total = MAX_OUT;
          count = 0;
          for (int i = 0; i < DEF_ROWS_LEFT && count < total; i++) begin
            for (int j = 0; j < DEF_COLS_RIGHT && count < total; j++) begin
              acc = 0;
              for (int k = 0; k < DEF_INNER_DIM; k++) begin
                pl = i * DEF_INNER_DIM + k;
                pr = k * DEF_COLS_RIGHT + j;
                a = (pl < STORE_DEPTH) ? longint'(left_m[pl]) : 0;
                b = (pr < STORE_DEPTH) ? longint'(right_m[pr]) : 0;
                acc += a * b;
              end
              w.row = i[COORD_W-1:0];
              w.col = j[COORD_W-1:0];
              w.value = acc[ACC_W-1:0];
              w.last = (count + 1 == total);
              pending_products.push_back(w);
              count++;
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_product(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                logic signed [ACC_W-1:0] value, logic last);
      product_word_t w;
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected word row %0d col %0d value %0d last %0d",
                 $time, row, col, value, last);
        errors++;
        return;
      end
      w = pending_products.pop_front();
      if (row !== w.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, w.row, row);
        errors++;
      end
      if (col !== w.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, w.col, col);
        errors++;
      end
      if (value !== w.value) begin
        $display("%0t: product_value expected %0d actual %0d", $time, w.value, value);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last expected %0d actual %0d", $time, w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic no_idle = 1'b0;
  logic rx_hold = 1'b0;
  int unsigned words_sent = 0;

  dmm_req_if req_ch ();
  dmm_res_if res_ch ();

  product_tracker tracker = new();

  dense_matrix_multiply DUT (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        tracker.apply_request(req_ch.cmd, req_ch.element_index, req_ch.element_value);
      if (res_ch.valid && res_ch.ready)
        tracker.check_product(res_ch.out_row, res_ch.out_col, res_ch.product_value,
                              res_ch.last);
    end
  end

  // receiver side
  initial begin
    res_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        rx_hold = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || rst)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.element_index <= idx;
    req_ch.element_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    if (cmd != CMD_NONE) words_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'shffff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned seq;
    int unsigned n;
    logic hold_done;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_NONE;
    req_ch.element_index = '0;
    req_ch.element_value = '0;
    hold_done = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero stores straight out of reset, ignored fields on the request
    send_word(CMD_PRODUCT, 4'hf, 16'sh7fff);
    send_word(CMD_WR_LEFT, 4'd0, 16'sh8000);
    send_word(CMD_WR_RIGHT, 4'd0, 16'sh8000);
    send_word(CMD_WR_LEFT, 4'd15, 16'sh7fff);
    send_word(CMD_WR_RIGHT, 4'd15, 16'sh8000);
    send_word(CMD_WR_LEFT, 4'd5, 16'shffff);
    send_word(CMD_WR_RIGHT, 4'd10, 16'sh7fff);
    send_word(CMD_PRODUCT, 4'd0, 16'sh0000);
    // unused command must leave the stores alone
    send_word(CMD_NONE, 4'd0, 16'sh8000);
    send_word(CMD_NONE, 4'd15, 16'sh7fff);
    send_word(CMD_PRODUCT, 4'ha, 16'sh5555);
    send_word(CMD_WR_LEFT, 4'd0, 16'sh0000);
    send_word(CMD_WR_RIGHT, 4'd15, 16'sh7fff);
    send_word(CMD_PRODUCT, 4'h5, 16'shaaaa);

    seq = 0;
    while (words_sent < RANDOM_WORDS + 14) begin
      no_idle = (seq >= 8 && seq < 14);
      case ($urandom_range(9))
        0: begin
          for (int i = 0; i < STORE_DEPTH; i++) begin
            send_word(CMD_WR_LEFT, IDX_W'(i), $urandom_range(1) ? 16'sh8000 : 16'sh7fff);
            send_word(CMD_WR_RIGHT, IDX_W'(i), $urandom_range(1) ? 16'sh8000 : 16'sh7fff);
          end
          send_word(CMD_PRODUCT, IDX_W'($urandom), VAL_W'($urandom));
        end
        1, 2: begin
          n = $urandom_range(1, 6);
          repeat (n)
            send_word(CMD_W'($urandom_range(3)), IDX_W'($urandom_range(15)),
                      VAL_W'($urandom));
        end
        default: begin
          n = $urandom_range(1, 24);
          repeat (n)
            send_word($urandom_range(1) ? CMD_WR_RIGHT : CMD_WR_LEFT,
                      IDX_W'($urandom_range(15)), rand_elem());
          send_word(CMD_PRODUCT, IDX_W'($urandom), VAL_W'($urandom));
          if (!hold_done && seq >= 3) begin
            // receiver stops while requests keep coming
            hold_done = 1'b1;
            rx_hold = 1'b1;
            send_word(CMD_WR_LEFT, IDX_W'($urandom_range(15)), rand_elem());
            send_word(CMD_PRODUCT, IDX_W'($urandom), VAL_W'($urandom));
            send_word(CMD_WR_RIGHT, IDX_W'($urandom_range(15)), rand_elem());
            send_word(CMD_PRODUCT, IDX_W'($urandom), VAL_W'($urandom));
          end
        end
      endcase
      seq++;
    end
    no_idle = 1'b0;
    req_ch.valid <= 1'b0;

    while (tracker.pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending_products.size() != 0)
      $display("%0t: %0d product words never arrived", $time,
               tracker.pending_products.size());
    if (tracker.errors == 0 && tracker.pending_products.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
